/* sv/x11rf_pkg.sv */
// Shared codes, widths and result type of the X11 request framer.
`timescale 1ns / 1ps

package x11rf_pkg;

    // Item operation codes.
    localparam logic [1:0] OP_DATA    = 2'd0;
    localparam logic [1:0] OP_QUERY   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Frame status codes.
    localparam logic [2:0] ST_NEED_MORE   = 3'd0;
    localparam logic [2:0] ST_COMPLETE    = 3'd1;
    localparam logic [2:0] ST_ZERO_LENGTH = 3'd2;
    localparam logic [2:0] ST_TOO_LARGE   = 3'd3;
    localparam logic [2:0] ST_TRUNCATED   = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_BYTE_ORDER   = 2'd0;
    localparam logic [1:0] REG_MAX_LENGTH   = 2'd1;
    localparam logic [1:0] REG_BIG_ENABLE   = 2'd2;
    localparam logic [1:0] REG_MAX_BIG_LEN  = 2'd3;

    localparam int          CFG_DATA_W       = 22;
    localparam int unsigned MAX_BIG_UNITS_DEF = 4194303;
    localparam logic [21:0] LEN_FIELD_MAX    = 22'h3F_FFFF;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  status;
        logic [23:0] byte_offset;
        logic [7:0]  byte_out;
        logic [7:0]  opcode_out;
        logic [7:0]  minor_data;
        logic [21:0] length_out;
        logic        request_end;
    } t_result;

endpackage

/* sv/x11_request_framer.sv */
// Top level of the X11 request framer: header decode, limit checks and output buffering.
`timescale 1ns / 1ps

// The framer takes one item per clock cycle while o_ready is high and returns exactly
// one result for each. A result is offered in the cycle after its input transfer when
// the output register is free, and otherwise waits in a one-entry skid register behind
// it; o_ready falls only when both hold results that have not been taken, so a stalled
// consumer costs no throughput until that second entry fills. All the
// per-byte work (offset count, header byte gathering, length decode in the selected
// byte order, limit compares and the completion compare) is one pass of logic on the
// frame state registers. The four-byte header yields opcode, minor data and a 16-bit
// length in 4-byte units; with big requests enabled a zero length announces an
// eight-byte header whose last four bytes carry a 32-bit length. Error and completion
// statuses latch, and further data bytes are refused, until a restart item clears the
// frame. An end-of-input query reports truncation when a partial request is pending and
// changes nothing. Configuration writes take effect at once and are meant to be made
// while no transfer is in flight.
module x11_request_framer
    import x11rf_pkg::*;
#(
    parameter int unsigned MAX_BIG_UNITS = MAX_BIG_UNITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_op,
    input  logic [7:0]            i_byte_value,

    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_accepted,
    output logic [2:0]            o_status,
    output logic [23:0]           o_byte_offset,
    output logic [7:0]            o_byte_out,
    output logic [7:0]            o_opcode_out,
    output logic [7:0]            o_minor_data,
    output logic [21:0]           o_length_out,
    output logic                  o_request_end
);

    localparam logic [31:0] MaxBig = 32'(MAX_BIG_UNITS);

    // Configuration registers.
    logic        r_byte_order;
    logic [15:0] r_max_length;
    logic        r_big_enable;
    logic [21:0] r_max_big_length;

    // Frame state. Only the low three gathered bytes are kept; the fourth comes
    // straight from the input on the byte that completes a length word.
    logic [2:0]  r_status,   n_status;
    logic [23:0] r_bytes,    n_bytes;
    logic [23:0] r_expected, n_expected;
    logic        r_ext,      n_ext;
    logic [7:0]  r_opcode,   n_opcode;
    logic [7:0]  r_minor,    n_minor;
    logic [23:0] r_gather,   n_gather;
    logic [21:0] r_length,   n_length;

    // Output buffer: main register plus skid entry.
    t_result     r_out;
    t_result     r_skid;
    logic        r_out_valid;
    logic        r_skid_valid;
    t_result     n_result;

    logic        in_xfer;
    logic        out_free;
    logic [23:0] bytes_inc;
    logic [31:0] gather_shift;
    logic [15:0] hdr_len;
    logic [31:0] ext_len;

    assign o_ready   = !r_skid_valid;
    assign in_xfer   = i_valid && o_ready;
    assign out_free  = !r_out_valid || i_ready;
    assign bytes_inc = r_bytes + 24'd1;

    // The header length is decoded from the gathered word as it stands after this byte.
    assign gather_shift = {r_gather, i_byte_value};
    assign hdr_len = r_byte_order ? gather_shift[15:0]
                                  : {gather_shift[7:0], gather_shift[15:8]};
    assign ext_len = r_byte_order ? gather_shift
                                  : {gather_shift[7:0], gather_shift[15:8],
                                     gather_shift[23:16], gather_shift[31:24]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_order     <= 1'b0;
            r_max_length     <= 16'hFFFF;
            r_big_enable     <= 1'b0;
            r_max_big_length <= LEN_FIELD_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_BYTE_ORDER:  r_byte_order     <= i_cfg_data[0];
                REG_MAX_LENGTH:  r_max_length     <= i_cfg_data[15:0];
                REG_BIG_ENABLE:  r_big_enable     <= i_cfg_data[0];
                REG_MAX_BIG_LEN: r_max_big_length <= i_cfg_data[21:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_status   = r_status;
        n_bytes    = r_bytes;
        n_expected = r_expected;
        n_ext      = r_ext;
        n_opcode   = r_opcode;
        n_minor    = r_minor;
        n_gather   = r_gather;
        n_length   = r_length;
        n_result   = '0;

        case (i_op)
            OP_RESTART: begin
                n_status   = ST_NEED_MORE;
                n_bytes    = 24'd0;
                n_expected = 24'd4;
                n_ext      = 1'b0;
                n_opcode   = 8'd0;
                n_minor    = 8'd0;
                n_gather   = 24'd0;
                n_length   = 22'd0;
            end
            OP_DATA: begin
                if (r_status == ST_NEED_MORE) begin
                    n_result.accepted    = 1'b1;
                    n_result.byte_offset = r_bytes;
                    n_result.byte_out    = i_byte_value;
                    n_bytes              = bytes_inc;
                    if (r_bytes < 24'd4 || (r_ext && r_bytes < 24'd8)) begin
                        n_gather = gather_shift[23:0];
                    end
                    // Fourth byte: ordinary header decode.
                    if (bytes_inc == 24'd4 && r_expected == 24'd4 && !r_ext) begin
                        n_opcode = gather_shift[31:24];
                        n_minor  = gather_shift[23:16];
                        n_gather = 24'd0;
                        n_length = {6'd0, hdr_len};
                        if (hdr_len == 16'd0) begin
                            if (!r_big_enable) begin
                                n_status = ST_ZERO_LENGTH;
                            end else begin
                                n_ext      = 1'b1;
                                n_expected = 24'd8;
                            end
                        end else if (hdr_len > r_max_length) begin
                            n_status = ST_TOO_LARGE;
                        end else begin
                            n_expected = {6'd0, hdr_len, 2'b00};
                        end
                    end
                    // Eighth byte of a big request: extended length decode.
                    if (n_status == ST_NEED_MORE && n_ext && bytes_inc == 24'd8 &&
                        n_expected == 24'd8) begin
                        n_gather = 24'd0;
                        n_length = (ext_len > {10'd0, LEN_FIELD_MAX}) ? LEN_FIELD_MAX
                                                                     : ext_len[21:0];
                        if (ext_len < 32'd2 || ext_len > {10'd0, r_max_big_length} ||
                            ext_len > MaxBig) begin
                            n_status = ST_TOO_LARGE;
                        end else begin
                            n_expected = {ext_len[21:0], 2'b00};
                        end
                    end
                    if (n_status == ST_NEED_MORE && bytes_inc == n_expected) begin
                        n_status             = ST_COMPLETE;
                        n_result.request_end = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        n_result.status = (i_op == OP_QUERY && n_status == ST_NEED_MORE && n_bytes != 24'd0)
                          ? ST_TRUNCATED : n_status;
        n_result.opcode_out = n_opcode;
        n_result.minor_data = n_minor;
        n_result.length_out = n_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status   <= ST_NEED_MORE;
            r_bytes    <= 24'd0;
            r_expected <= 24'd4;
            r_ext      <= 1'b0;
            r_opcode   <= 8'd0;
            r_minor    <= 8'd0;
            r_gather   <= 24'd0;
            r_length   <= 22'd0;
        end else if (in_xfer) begin
            r_status   <= n_status;
            r_bytes    <= n_bytes;
            r_expected <= n_expected;
            r_ext      <= n_ext;
            r_opcode   <= n_opcode;
            r_minor    <= n_minor;
            r_gather   <= n_gather;
            r_length   <= n_length;
        end
    end

    // When the output register can move, it drains the skid entry first; new input is
    // only taken while the skid entry is empty, so no result is ever overwritten.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_xfer;
            end
        end else if (in_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_xfer) begin
                r_out <= n_result;
            end
        end else if (in_xfer) begin
            r_skid <= n_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_accepted    = r_out.accepted;
    assign o_status      = r_out.status;
    assign o_byte_offset = r_out.byte_offset;
    assign o_byte_out    = r_out.byte_out;
    assign o_opcode_out  = r_out.opcode_out;
    assign o_minor_data  = r_out.minor_data;
    assign o_length_out  = r_out.length_out;
    assign o_request_end = r_out.request_end;

endmodule

/* sv/x11rf_checker.sv */
// Port-level checks of the X11 request framer and the bind that attaches them.
`timescale 1ns / 1ps

module x11rf_assertions
    import x11rf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_accepted,
    input logic [2:0]  o_status,
    input logic [23:0] o_byte_offset,
    input logic [7:0]  o_byte_out,
    input logic        o_request_end
);

    // A stalled result stays offered, with its status and byte offset unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_byte_offset))
        else $error("stalled result changed");

    // The closing byte of a request is a taken byte reported as complete.
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_request_end |-> o_accepted && o_status == ST_COMPLETE)
        else $error("request end without a completing byte");

    // A refused or non-data transfer carries no byte or offset.
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_accepted |-> o_byte_offset == 24'd0 && o_byte_out == 8'd0 &&
                                   !o_request_end)
        else $error("byte fields set on a refused transfer");

    // Truncation is only ever reported by a query, never on a taken byte.
    a_trunc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_TRUNCATED |-> !o_accepted)
        else $error("truncation reported on a taken byte");

endmodule

bind x11_request_framer x11rf_assertions u_x11rf_assertions (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_accepted    (o_accepted),
    .o_status      (o_status),
    .o_byte_offset (o_byte_offset),
    .o_byte_out    (o_byte_out),
    .o_request_end (o_request_end)
);

/* dv/x11rf_checker.sv */
// Scoreboard for the X11 request framer: predicts each result and compares it on transfer.
`timescale 1ns / 1ps

module x11rf_checker
    import x11rf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [1:0]            i_op,
    input  logic [7:0]            i_byte_value,

    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_result               i_result,

    output int                    o_fail_count,
    output int                    o_pending
);

    // Register copies.
    logic        cfg_msb_first;
    logic [15:0] cfg_max_len;
    logic        cfg_big_en;
    logic [21:0] cfg_max_big;

    // Frame state copies.
    logic [2:0]  fr_status;
    logic [23:0] seen_cnt;
    logic [23:0] need_cnt;
    logic        ext_hdr;
    logic [7:0]  major_opc;
    logic [7:0]  hdr_data;
    logic [31:0] len_gather;
    logic [21:0] len_units;

    t_result frame_echo_q[$];
    t_result want_res;
    int      fail_count  = 0;
    int      pending_cnt = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_cnt;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < 100)
            $display("%0t framer mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
        fail_count++;
    endtask

    function automatic void clear_frame();
        fr_status  = ST_NEED_MORE;
        seen_cnt   = '0;
        need_cnt   = 24'd4;
        ext_hdr    = 1'b0;
        major_opc  = '0;
        hdr_data   = '0;
        len_gather = '0;
        len_units  = '0;
    endfunction

    // Advances the frame by one item and returns the result it should produce.
    function automatic t_result frame_step(input logic [1:0] op, input logic [7:0] b);
        t_result     r;
        logic [23:0] off;
        logic [15:0] len16;
        logic [31:0] len32;
        logic [31:0] big_lim;
        r = '0;
        if (op == OP_RESTART) begin
            clear_frame();
        end else if (op == OP_DATA && fr_status == ST_NEED_MORE) begin
            off           = seen_cnt;
            r.accepted    = 1'b1;
            r.byte_offset = off;
            r.byte_out    = b;
            seen_cnt      = seen_cnt + 24'd1;
            if (off < 24'd4 || (ext_hdr && off < 24'd8))
                len_gather = {len_gather[23:0], b};
            // Basic header: opcode, data byte and a 16-bit length.
            if (seen_cnt == 24'd4 && need_cnt == 24'd4 && !ext_hdr) begin
                len16      = cfg_msb_first ? len_gather[15:0]
                                           : {len_gather[7:0], len_gather[15:8]};
                major_opc  = len_gather[31:24];
                hdr_data   = len_gather[23:16];
                len_gather = '0;
                len_units  = {6'd0, len16};
                if (len16 == 16'd0) begin
                    if (!cfg_big_en) begin
                        fr_status = ST_ZERO_LENGTH;
                    end else begin
                        ext_hdr  = 1'b1;
                        need_cnt = 24'd8;
                    end
                end else if (len16 > cfg_max_len) begin
                    fr_status = ST_TOO_LARGE;
                end else begin
                    need_cnt = {6'd0, len16, 2'b00};
                end
            end
            // Big-requests header: bytes four to seven hold a 32-bit length.
            if (fr_status == ST_NEED_MORE && ext_hdr && seen_cnt == 24'd8 &&
                need_cnt == 24'd8) begin
                len32   = cfg_msb_first ? len_gather
                                        : {len_gather[7:0], len_gather[15:8],
                                           len_gather[23:16], len_gather[31:24]};
                big_lim = {10'd0, cfg_max_big};
                if (big_lim > MAX_BIG_UNITS_DEF) big_lim = MAX_BIG_UNITS_DEF;
                if (big_lim > {10'd0, LEN_FIELD_MAX}) big_lim = {10'd0, LEN_FIELD_MAX};
                len_gather = '0;
                len_units  = (len32 > {10'd0, LEN_FIELD_MAX}) ? LEN_FIELD_MAX : len32[21:0];
                if (len32 < 32'd2 || len32 > big_lim)
                    fr_status = ST_TOO_LARGE;
                else
                    need_cnt = {len32[21:0], 2'b00};
            end
            if (fr_status == ST_NEED_MORE && seen_cnt == need_cnt) begin
                fr_status     = ST_COMPLETE;
                r.request_end = 1'b1;
            end
        end
        r.status = fr_status;
        if (op == OP_QUERY && fr_status == ST_NEED_MORE && seen_cnt != 24'd0)
            r.status = ST_TRUNCATED;
        r.opcode_out = major_opc;
        r.minor_data = hdr_data;
        r.length_out = len_units;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame();
            cfg_msb_first = 1'b0;
            cfg_max_len   = 16'hFFFF;
            cfg_big_en    = 1'b0;
            cfg_max_big   = LEN_FIELD_MAX;
            frame_echo_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (frame_echo_q.size() == 0) begin
                    report_mismatch("result with nothing expected",
                                    32'(i_result.status), 32'd0);
                end else begin
                    want_res = frame_echo_q.pop_front();
                    if (i_result.accepted !== want_res.accepted)
                        report_mismatch("accepted", 32'(i_result.accepted),
                                        32'(want_res.accepted));
                    if (i_result.status !== want_res.status)
                        report_mismatch("status", 32'(i_result.status),
                                        32'(want_res.status));
                    if (i_result.byte_offset !== want_res.byte_offset)
                        report_mismatch("byte_offset", 32'(i_result.byte_offset),
                                        32'(want_res.byte_offset));
                    if (i_result.byte_out !== want_res.byte_out)
                        report_mismatch("byte_out", 32'(i_result.byte_out),
                                        32'(want_res.byte_out));
                    if (i_result.opcode_out !== want_res.opcode_out)
                        report_mismatch("opcode_out", 32'(i_result.opcode_out),
                                        32'(want_res.opcode_out));
                    if (i_result.minor_data !== want_res.minor_data)
                        report_mismatch("minor_data", 32'(i_result.minor_data),
                                        32'(want_res.minor_data));
                    if (i_result.length_out !== want_res.length_out)
                        report_mismatch("length_out", 32'(i_result.length_out),
                                        32'(want_res.length_out));
                    if (i_result.request_end !== want_res.request_end)
                        report_mismatch("request_end", 32'(i_result.request_end),
                                        32'(want_res.request_end));
                end
            end
            if (i_in_valid && i_in_ready)
                frame_echo_q.push_back(frame_step(i_op, i_byte_value));
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_BYTE_ORDER:  cfg_msb_first = i_cfg_data[0];
                    REG_MAX_LENGTH:  cfg_max_len   = i_cfg_data[15:0];
                    REG_BIG_ENABLE:  cfg_big_en    = i_cfg_data[0];
                    REG_MAX_BIG_LEN: cfg_max_big   = i_cfg_data[21:0];
                    default: ;
                endcase
            end
        end
        pending_cnt = frame_echo_q.size();
    end

endmodule

/* dv/tb_top.sv */
// Testbench top for the X11 request framer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

// The top drives both channels of the framer and leaves all prediction and comparison
// to the checker instantiated beside it. The run is split into phases, each with its own
// register setting; registers are only written once every expected result has come back.
// Each phase sends mostly well-formed requests (basic and big-requests headers in the
// configured byte order, random payload), mixed with truncated requests, refused extra
// bytes, end-of-input queries, unused operations and a little noise, most requests
// closed by a restart so that the next one starts from a clean frame.
module tb_top;
    import x11rf_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         PHASE_ITEMS = 225;
    localparam int         NUM_PHASES  = 6;
    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         TAIL_CYCLES = 4;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_we     = 1'b0;
    logic [1:0]            i_cfg_addr   = REG_BYTE_ORDER;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  i_valid      = 1'b0;
    logic [1:0]            i_op         = OP_DATA;
    logic [7:0]            i_byte_value = 8'd0;
    logic                  i_ready      = 1'b0;

    logic                  o_ready;
    logic                  o_valid;
    logic                  o_accepted;
    logic [2:0]            o_status;
    logic [23:0]           o_byte_offset;
    logic [7:0]            o_byte_out;
    logic [7:0]            o_opcode_out;
    logic [7:0]            o_minor_data;
    logic [21:0]           o_length_out;
    logic                  o_request_end;

    t_result dut_res;
    int      fail_count;
    int      pending_cnt;

    // Mirror of the registers, used only to shape requests.
    logic        cur_msb_first;
    logic [15:0] cur_max_len;
    logic        cur_big_en;
    logic [21:0] cur_max_big;

    // When set, neither side idles, so the block runs at full rate.
    logic calm_mode = 1'b0;
    int   items_sent = 0;
    int   cycle_count = 0;
    int   rx_hold = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    x11_request_framer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_byte_value  (i_byte_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_accepted    (o_accepted),
        .o_status      (o_status),
        .o_byte_offset (o_byte_offset),
        .o_byte_out    (o_byte_out),
        .o_opcode_out  (o_opcode_out),
        .o_minor_data  (o_minor_data),
        .o_length_out  (o_length_out),
        .o_request_end (o_request_end)
    );

    assign dut_res = {o_accepted, o_status, o_byte_offset, o_byte_out, o_opcode_out,
                      o_minor_data, o_length_out, o_request_end};

    x11rf_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_op         (i_op),
        .i_byte_value (i_byte_value),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_result     (dut_res),
        .o_fail_count (fail_count),
        .o_pending    (pending_cnt)
    );

    // Gap lengths: mostly none, sometimes a few cycles, rarely a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // The result side stalls on its own random schedule.
    always @(posedge i_clk) begin
        if (calm_mode) begin
            rx_hold = 0;
            i_ready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            i_ready <= 1'b0;
        end else begin
            rx_hold = pick_gap();
            i_ready <= (rx_hold == 0);
            if (rx_hold > 0) rx_hold = rx_hold - 1;
        end
    end

    // Offers one item after an optional gap and returns at the edge of its transfer.
    task automatic send_item(input logic [1:0] op, input logic [7:0] b);
        int gap;
        gap = calm_mode ? 0 : pick_gap();
        repeat (gap) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_byte_value <= b;
        do @(posedge i_clk); while (!o_ready);
        if (op != OP_UNUSED) items_sent++;
    endtask

    // Holds the sender back until every expected result has come, then lets the
    // block settle.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_cnt != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic msb_first, input logic [15:0] max_len,
                              input logic big_en, input logic [21:0] max_big);
        drain_results();
        cur_msb_first = msb_first;
        cur_max_len   = max_len;
        cur_big_en    = big_en;
        cur_max_big   = max_big;
        write_reg(REG_BYTE_ORDER, {21'd0, msb_first});
        write_reg(REG_MAX_LENGTH, {6'd0, max_len});
        write_reg(REG_BIG_ENABLE, {21'd0, big_en});
        write_reg(REG_MAX_BIG_LEN, max_big);
        i_cfg_we <= 1'b0;
    endtask

    // Sends the first n_bytes data bytes of a request whose header carries the given
    // fields in the current byte order; bytes past the header are random payload.
    task automatic send_frame(input logic [7:0] opc, input logic [7:0] minor,
                              input logic [15:0] len16, input logic [31:0] big_len,
                              input int n_bytes);
        logic [7:0] b;
        for (int i = 0; i < n_bytes; i++) begin
            b = 8'($urandom());
            case (i)
                0: b = opc;
                1: b = minor;
                2: b = cur_msb_first ? len16[15:8] : len16[7:0];
                3: b = cur_msb_first ? len16[7:0] : len16[15:8];
                4, 5, 6, 7: begin
                    if (len16 == 16'd0)
                        b = cur_msb_first ? big_len[8*(7-i) +: 8] : big_len[8*(i-4) +: 8];
                end
                default: ;
            endcase
            send_item(OP_DATA, b);
        end
    endtask

    // One request of random shape, usually closed by a restart.
    task automatic random_request();
        logic [15:0] len16;
        logic [31:0] big_len;
        logic [31:0] big_lim;
        int          r;
        int          m;
        int          upper;
        int          full;
        int          n_bytes;
        r       = $urandom_range(0, 99);
        big_len = $urandom();
        big_lim = {10'd0, cur_max_big};
        // A little noise between requests.
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 4))
                send_item(2'($urandom_range(0, 3)), 8'($urandom()));
        end
        if (cur_big_en && r < 35) begin
            len16 = 16'd0;
            if ($urandom_range(0, 4) != 0 && big_lim >= 32'd2) begin
                big_len = $urandom_range(2, (big_lim < 32'd12) ? big_lim : 12);
            end else begin
                case ($urandom_range(0, 3))
                    0: big_len = $urandom_range(0, 1);
                    1: big_len = big_lim + 32'd1;
                    2: big_len = 32'hFFFF_FFFF;
                    default: ;
                endcase
            end
        end else if (r < 45) begin
            // Header errors: zero length, or a length above the ordinary limit.
            if (cur_max_len != 16'hFFFF && $urandom_range(0, 1) == 1)
                len16 = 16'($urandom_range(int'(cur_max_len) + 1, 65535));
            else
                len16 = 16'd0;
        end else begin
            upper = (r > 97) ? 40 : 12;
            if (int'(cur_max_len) < upper) upper = int'(cur_max_len);
            len16 = (upper == 0) ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, upper));
            // Wide lengths, mostly far too long to finish, exercise every length bit.
            if (r >= 90 && r < 95) len16 = 16'($urandom());
        end

        if (len16 == 16'd0 && cur_big_en)
            full = (big_len >= 32'd2 && big_len <= big_lim) ? int'(big_len) * 4 : 8;
        else if (len16 == 16'd0 || len16 > cur_max_len)
            full = 4;
        else
            full = int'(len16) * 4;

        m = $urandom_range(0, 99);
        if (m < 75 && full <= 200)
            n_bytes = full;
        else if (m < 90 || full > 200)
            n_bytes = $urandom_range(1, (full - 1 < 30) ? full - 1 : 30);
        else
            n_bytes = full + $urandom_range(1, 3);

        send_frame(8'($urandom()), 8'($urandom()), len16, big_len, n_bytes);
        if ($urandom_range(0, 2) == 0) send_item(OP_QUERY, 8'($urandom()));
        if ($urandom_range(0, 19) == 0) send_item(OP_UNUSED, 8'($urandom()));
        if ($urandom_range(0, 99) < 92) send_item(OP_RESTART, 8'($urandom()));
    endtask

    // Watchdog on the whole run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    initial begin
        int  phase_stop;
        bit  paused;
        paused = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: set_config(1'b0, 16'hFFFF, 1'b0, LEN_FIELD_MAX);
                1: set_config(1'b1, 16'd2, 1'b1, LEN_FIELD_MAX);
                // Ordinary limit of zero and the smallest big-requests limit.
                2: set_config(1'b0, 16'd0, 1'b1, 22'd2);
                // A big-requests limit under two makes every extended length too large.
                3: set_config(1'b1, 16'd1, 1'b1, 22'd0);
                default: set_config(1'($urandom_range(0, 1)),
                                    16'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 16)
                                                                   : $urandom_range(17, 65535)),
                                    (ph == 4) ? 1'b1 : 1'($urandom_range(0, 1)),
                                    22'(($urandom_range(0, 1) == 1) ? $urandom_range(2, 16)
                                                                    : $urandom_range(17, 4194303)));
            endcase
            calm_mode = (ph == 3);

            if (ph == 0) begin
                // Query on a fresh frame, a one-unit request with extreme header bytes,
                // a refused byte and an unused operation after completion, then a
                // truncated request reported by an end-of-input query.
                send_item(OP_QUERY, 8'hFF);
                send_frame(8'hFF, 8'h00, 16'd1, 32'd0, 4);
                send_item(OP_DATA, 8'hFF);
                send_item(OP_UNUSED, 8'hAA);
                send_item(OP_RESTART, 8'h00);
                send_frame(8'h00, 8'hFF, 16'hFFFF, 32'd0, 2);
                send_item(OP_QUERY, 8'h00);
                send_item(OP_RESTART, 8'hFF);
            end else if (ph == 1) begin
                // Length two is an ordinary eight-byte request, not a big one.
                send_frame(8'h80, 8'h7F, 16'd2, 32'd0, 8);
                send_item(OP_RESTART, 8'h00);
                // An extended length beyond the output field saturates and is too large.
                send_frame(8'h01, 8'h02, 16'd0, 32'hFFFF_FFFF, 8);
                send_item(OP_RESTART, 8'h00);
            end

            phase_stop = items_sent + PHASE_ITEMS;
            while (items_sent < phase_stop) begin
                random_request();
                // Once in the run the sender waits for all outstanding results.
                if (ph == 4 && !paused && items_sent >= phase_stop - PHASE_ITEMS / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end

        drain_results();
        if (fail_count == 0 && pending_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
sv/x11rf_pkg.sv
sv/x11_request_framer.sv
sv/x11rf_checker.sv
dv/x11rf_checker.sv
dv/tb_top.sv
